/* hdl/transposition_table_depth_replace_defines.svh */
// Assertion macros shared by the transposition table top level and remainder unit.
`ifndef TRANSPOSITION_TABLE_DEPTH_REPLACE_DEFINES_SVH
`define TRANSPOSITION_TABLE_DEPTH_REPLACE_DEFINES_SVH

// Checked at every rising clock edge outside of reset.
`define TTDR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define TTDR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hdl/ttdr_pkg.sv */
// Shared types, widths and codes of the transposition table.
package ttdr_pkg;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int KIND_W  = 8;
    localparam int MOVE_W  = 16;
    localparam int REQ_W   = 2;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    localparam int SLOTS_DEF = 4096;

    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PROBE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_AGE    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_CODE   = 1'b1;

    localparam logic [CFG_W-1:0]  SLOTS_IN_USE_RST = 13'd4096;
    localparam logic [KIND_W-1:0] EXACT_CODE_RST   = 8'd0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_AGE,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
        logic [MOVE_W-1:0]         move;
    } t_entry;

    typedef struct packed {
        logic rd;
        logic we_valid;
        logic valid_val;
        logic we_old;
        logic old_val;
        logic we_data;
    } t_tbl_ctl;

endpackage

/* hdl/ttdr_req_if.sv */
// Request channel of the transposition table.
interface ttdr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [ttdr_pkg::REQ_W-1:0]           req_type;
    logic [ttdr_pkg::KEY_W-1:0]           position_key;
    logic signed [ttdr_pkg::SCORE_W-1:0]  score_in;
    logic [ttdr_pkg::DEPTH_W-1:0]         depth_in;
    logic [ttdr_pkg::KIND_W-1:0]          node_kind_in;
    logic [ttdr_pkg::MOVE_W-1:0]          move_in;

    modport source (
        output valid, req_type, position_key, score_in, depth_in, node_kind_in, move_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, position_key, score_in, depth_in, node_kind_in, move_in,
        output ready
    );
endinterface

/* hdl/ttdr_rsp_if.sv */
// Result channel of the transposition table.
interface ttdr_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [ttdr_pkg::SCORE_W-1:0]  score_out;
    logic [ttdr_pkg::DEPTH_W-1:0]         depth_out;
    logic [ttdr_pkg::KIND_W-1:0]          node_kind_out;
    logic [ttdr_pkg::MOVE_W-1:0]          move_out;
    logic [ttdr_pkg::COUNT_W-1:0]         occupied_count;

    modport source (
        output valid, hit, score_out, depth_out, node_kind_out, move_out, occupied_count,
        input  ready
    );
    modport sink (
        input  valid, hit, score_out, depth_out, node_kind_out, move_out, occupied_count,
        output ready
    );
endinterface

/* hdl/transposition_table_depth_replace.sv */
// Top level of the direct-mapped transposition table with depth-preferred replacement.
//
// Requests arrive on i_req (valid/ready); each request gives exactly one result transfer
// on o_rsp. A store or probe first reduces the 64-bit key modulo the configured size in a
// bit-serial remainder unit, then reads the slot and decides or writes it; its result
// waits in the push state until the output register is free and then enters it. An age
// request walks every slot, one per cycle, writing its old flag, and then pushes its
// result. An unused request code goes straight to the push state. One request is worked
// on at a time; i_req is ready only while the sequencer is idle, so the next request
// transfer can follow only after the last result has entered the output register.
// After reset a clearing pass writes every valid flag to zero, one slot per cycle; no
// request is taken meanwhile, while configuration writes through i_cfg_we/i_cfg_idx/
// i_cfg_data are taken at any time. Configuration should only change while the block is
// idle. A finished result waits in the output register while the receiver stalls; the
// next request can still be taken and worked on, and its result waits until the register
// is free.
`include "transposition_table_depth_replace_defines.svh"

module transposition_table_depth_replace #(
    parameter int SLOTS = ttdr_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ttdr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ttdr_pkg::CFG_W-1:0]     i_cfg_data,
    ttdr_req_if.sink                       i_req,
    ttdr_rsp_if.source                     o_rsp
);
    import ttdr_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int SW = $clog2(SLOTS + 1);

    // Configuration registers.
    logic [CFG_W-1:0]  r_slots;
    logic [KIND_W-1:0] r_exact;

    // Sequencer.
    t_state r_state;
    t_state n_state;
    logic [IW-1:0] r_walk;
    logic          w_walk_last;

    // The request being worked on.
    logic [REQ_W-1:0] r_req;
    t_entry           r_item;

    // Result waiting to enter the output register.
    logic                 r_p_hit;
    t_entry               r_p_entry;
    logic [COUNT_W-1:0]   r_filled;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_hit;
    t_entry               r_out_entry;
    logic [COUNT_W-1:0]   r_out_count;

    // Datapath signals.
    logic [31:0]   w_size_ext;
    logic [SW-1:0] w_size;
    logic          w_accept;
    logic          w_div_start;
    logic          w_div_done;
    logic [SW-1:0] w_rem;
    logic          w_out_free;
    logic          w_push;
    t_tbl_ctl      w_ctl;
    logic [IW-1:0] w_addr;
    logic          w_slot_valid;
    logic          w_slot_old;
    t_entry        w_slot;
    logic          w_replace;
    logic          w_probe_hit;

    // A size of zero acts as one; a size above the table acts as the whole table.
    always_comb begin
        w_size_ext = {19'b0, r_slots};
        if (w_size_ext == 32'd0) begin
            w_size_ext = 32'd1;
        end else if (w_size_ext > 32'(SLOTS)) begin
            w_size_ext = 32'(SLOTS);
        end
        w_size = w_size_ext[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= SLOTS_IN_USE_RST;
            r_exact <= EXACT_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SLOTS_IN_USE: r_slots <= i_cfg_data;
                CFG_EXACT_CODE:   r_exact <= i_cfg_data[KIND_W-1:0];
                default:          ;
            endcase
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_div_start = w_accept &&
                         (i_req.req_type == REQ_STORE || i_req.req_type == REQ_PROBE);
    assign w_walk_last = (r_walk == IW'(SLOTS - 1));
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_push      = (r_state == S_PUSH) && w_out_free;

    ttdr_rem #(
        .SW (SW)
    ) u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_key   (i_req.position_key),
        .i_den   (w_size),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    // The remainder is always below the effective size, so its low bits address the slot.
    assign w_addr = (r_state == S_CLEAR || r_state == S_AGE) ? r_walk : w_rem[IW-1:0];

    ttdr_table #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_addr  (w_addr),
        .i_wdata (r_item),
        .o_valid (w_slot_valid),
        .o_old   (w_slot_old),
        .o_rdata (w_slot)
    );

    // Depth-preferred replacement; a store never looks at the stored key.
    assign w_replace = !w_slot_valid || w_slot_old ||
                       (w_slot.depth < r_item.depth) ||
                       (w_slot.depth == r_item.depth && r_item.kind == r_exact &&
                        w_slot.kind != r_exact);
    assign w_probe_hit = w_slot_valid && (w_slot.key == r_item.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_ctl   = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_ctl.we_valid = 1'b1;
                if (w_walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    priority if (w_div_start) begin
                        n_state = S_DIV;
                    end else if (i_req.req_type == REQ_AGE) begin
                        n_state = S_AGE;
                    end else begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_ctl.rd = 1'b1;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_req == REQ_STORE && w_replace) begin
                    w_ctl.we_valid  = 1'b1;
                    w_ctl.valid_val = 1'b1;
                    w_ctl.we_old    = 1'b1;
                    w_ctl.we_data   = 1'b1;
                end
                n_state = S_PUSH;
            end
            S_AGE: begin
                // Flags of empty slots do not matter, so every slot is marked blindly.
                w_ctl.we_old  = 1'b1;
                w_ctl.old_val = 1'b1;
                if (w_walk_last) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (r_state == S_CLEAR || r_state == S_AGE) begin
            r_walk <= w_walk_last ? '0 : r_walk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (r_state == S_LOOK && r_req == REQ_STORE && !w_slot_valid) begin
            r_filled <= r_filled + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req          <= i_req.req_type;
            r_item.key     <= i_req.position_key;
            r_item.score   <= i_req.score_in;
            r_item.depth   <= i_req.depth_in;
            r_item.kind    <= i_req.node_kind_in;
            r_item.move    <= i_req.move_in;
            r_p_hit        <= 1'b0;
            r_p_entry      <= '0;
        end else if (r_state == S_LOOK && r_req == REQ_PROBE && w_probe_hit) begin
            r_p_hit   <= 1'b1;
            r_p_entry <= w_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_hit   <= r_p_hit;
            r_out_entry <= r_p_entry;
            r_out_count <= r_filled;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.hit            = r_out_hit;
    assign o_rsp.score_out      = r_out_entry.score;
    assign o_rsp.depth_out      = r_out_entry.depth;
    assign o_rsp.node_kind_out  = r_out_entry.kind;
    assign o_rsp.move_out       = r_out_entry.move;
    assign o_rsp.occupied_count = r_out_count;

    `TTDR_ASSERT(a_keyed_req_divides, w_div_start |=> (r_state == S_DIV), "store or probe did not start the remainder")
    `TTDR_ASSERT(a_count_only_on_store, (r_state != S_LOOK) |=> $stable(r_filled), "fill count moved outside a store")
    `TTDR_ASSERT(a_push_waits, (r_state == S_PUSH && r_out_valid && !o_rsp.ready) |=> (r_state == S_PUSH), "result pushed over an unaccepted one")

endmodule

/* hdl/ttdr_rem.sv */
// Bit-serial remainder unit: 64-bit key modulo the table size, one key bit per cycle.
`include "transposition_table_depth_replace_defines.svh"

module ttdr_rem #(
    parameter int SW = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ttdr_pkg::KEY_W-1:0] i_key,
    input  logic [SW-1:0]              i_den,
    output logic                       o_done,
    output logic [SW-1:0]              o_rem
);
    import ttdr_pkg::*;

    localparam int CW = $clog2(KEY_W);

    logic [KEY_W-1:0] r_key;
    logic [SW-1:0]    r_den;
    logic [SW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [SW:0]      w_trial;
    logic [SW:0]      w_diff;
    logic [SW-1:0]    n_rem;

    // One restoring step: shift the next key bit in, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_key[r_cnt]};
        w_diff  = w_trial - {1'b0, r_den};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_diff[SW-1:0];
        end else begin
            n_rem = w_trial[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(KEY_W - 1);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `TTDR_ASSERT(a_start_clears_done, i_start |=> !o_done, "remainder reported done right after start")
    `TTDR_ASSERT(a_rem_below_den, r_run |-> (r_rem < r_den), "partial remainder reached the divisor")
    `TTDR_ASSERT(a_last_step_done, (r_run && r_cnt == '0 && !i_start) |=> (o_done && !r_run), "last step did not finish the remainder")

endmodule

/* hdl/ttdr_table.sv */
// Slot storage: valid flags, old flags and entry data, one address per cycle.
module ttdr_table #(
    parameter int SLOTS = ttdr_pkg::SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic                        i_clk,
    input  ttdr_pkg::t_tbl_ctl          i_ctl,
    input  logic [IW-1:0]               i_addr,
    input  ttdr_pkg::t_entry            i_wdata,
    output logic                        o_valid,
    output logic                        o_old,
    output ttdr_pkg::t_entry            o_rdata
);
    import ttdr_pkg::*;

    logic   r_valid_mem [SLOTS];
    logic   r_old_mem   [SLOTS];
    t_entry r_data_mem  [SLOTS];

    logic   r_valid_q;
    logic   r_old_q;
    t_entry r_data_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_valid) begin
            r_valid_mem[i_addr] <= i_ctl.valid_val;
        end
        if (i_ctl.rd) begin
            r_valid_q <= r_valid_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_old) begin
            r_old_mem[i_addr] <= i_ctl.old_val;
        end
        if (i_ctl.rd) begin
            r_old_q <= r_old_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_data) begin
            r_data_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_data_q <= r_data_mem[i_addr];
        end
    end

    assign o_valid = r_valid_q;
    assign o_old   = r_old_q;
    assign o_rdata = r_data_q;

endmodule

/* dv/transposition_table_depth_replace_tb.sv */
// Self-checking testbench for the depth-preferred transposition table.
module transposition_table_depth_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttdr_pkg::*;

    localparam int SLOTS          = SLOTS_DEF;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 5;
    // This many quiet cycles at the end is enough for any stray result to show up.
    localparam int DRAIN_CYCLES   = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 400;
    localparam int AGE_BUDGET     = 16;
    localparam int RECENT_DEPTH   = 32;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 62;
    localparam int PRESSURE_PHASE = 3;
    // Watchdog limit in nanoseconds. A correct run, with its clearing pass and every age
    // walk through the whole table, ends well before it.
    localparam longint LIMIT_NS   = 64'd12_000_000;

    typedef struct packed {
        logic [REQ_W-1:0]          op;
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
        logic [MOVE_W-1:0]         move;
    } t_request;

    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [KIND_W-1:0]         kind;
        logic [MOVE_W-1:0]         move;
        logic [COUNT_W-1:0]        occupied;
    } t_answer;

    // The class keeps a shadow copy of the table and of both registers. From these it
    // works out the answer that each accepted request must produce. It also checks the
    // answers in order.
    class table_mirror;
        bit                        filled_flag[SLOTS];
        bit                        old_flag[SLOTS];
        logic [KEY_W-1:0]          key_at[SLOTS];
        logic signed [SCORE_W-1:0] score_at[SLOTS];
        logic [DEPTH_W-1:0]        depth_at[SLOTS];
        logic [KIND_W-1:0]         kind_at[SLOTS];
        logic [MOVE_W-1:0]         move_at[SLOTS];
        int unsigned               filled_total;
        logic [CFG_W-1:0]          size_reg;
        logic [KIND_W-1:0]         exact_reg;
        t_answer                   due_answers[$];
        int unsigned               errors;
        int unsigned               stores;
        int unsigned               probes;
        int unsigned               hits;
        int unsigned               ages;
        int unsigned               unused_ops;
        int unsigned               answers;

        function new();
            foreach (filled_flag[i]) begin
                filled_flag[i] = 1'b0;
                old_flag[i]    = 1'b0;
            end
            filled_total = 0;
            size_reg     = SLOTS_IN_USE_RST;
            exact_reg    = EXACT_CODE_RST;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_SLOTS_IN_USE) begin
                size_reg = data;
            end else if (idx == CFG_EXACT_CODE) begin
                exact_reg = data[KIND_W-1:0];
            end
        endfunction

        // A size of zero acts as one. A size above the built table is clamped to it.
        function int unsigned slot_count();
            int unsigned n;
            n = size_reg;
            if (n == 0) n = 1;
            if (n > SLOTS) n = SLOTS;
            return n;
        endfunction

        function void fill_slot(int unsigned idx, t_request r);
            key_at[idx]      = r.key;
            score_at[idx]    = r.score;
            depth_at[idx]    = r.depth;
            kind_at[idx]     = r.kind;
            move_at[idx]     = r.move;
            old_flag[idx]    = 1'b0;
            filled_flag[idx] = 1'b1;
        endfunction

        function void note_request(t_request r);
            t_answer     a;
            int unsigned idx;
            a   = '0;
            idx = int'(r.key % 64'(slot_count()));
            case (r.op)
                REQ_STORE: begin
                    stores++;
                    if (!filled_flag[idx]) begin
                        fill_slot(idx, r);
                        filled_total++;
                    end else if (old_flag[idx] || depth_at[idx] < r.depth ||
                                 (depth_at[idx] == r.depth && r.kind == exact_reg &&
                                  kind_at[idx] != exact_reg)) begin
                        fill_slot(idx, r);
                    end
                end
                REQ_PROBE: begin
                    probes++;
                    if (filled_flag[idx] && key_at[idx] == r.key) begin
                        hits++;
                        a.hit   = 1'b1;
                        a.score = score_at[idx];
                        a.depth = depth_at[idx];
                        a.kind  = kind_at[idx];
                        a.move  = move_at[idx];
                    end
                end
                REQ_AGE: begin
                    ages++;
                    // Every filled slot ages, including slots beyond the present size.
                    foreach (filled_flag[i]) begin
                        if (filled_flag[i]) old_flag[i] = 1'b1;
                    end
                end
                default: begin
                    unused_ops++;
                end
            endcase
            a.occupied = COUNT_W'(filled_total);
            due_answers.push_back(a);
        endfunction

        task report(string what);
            $display("%0t ns: mismatch on result %0d: %s", $time, answers, what);
            errors++;
        endtask

        task check_answer(t_answer got);
            t_answer want;
            answers++;
            if (due_answers.size() == 0) begin
                report($sformatf("result with none outstanding (hit %0d, count %0d)",
                                 got.hit, got.occupied));
                return;
            end
            want = due_answers.pop_front();
            if (got.hit !== want.hit)
                report($sformatf("hit %0d, expected %0d", got.hit, want.hit));
            if (got.score !== want.score)
                report($sformatf("score_out %0d, expected %0d", got.score, want.score));
            if (got.depth !== want.depth)
                report($sformatf("depth_out %0d, expected %0d", got.depth, want.depth));
            if (got.kind !== want.kind)
                report($sformatf("node_kind_out %0d, expected %0d", got.kind, want.kind));
            if (got.move !== want.move)
                report($sformatf("move_out %0d, expected %0d", got.move, want.move));
            if (got.occupied !== want.occupied)
                report($sformatf("occupied_count %0d, expected %0d",
                                 got.occupied, want.occupied));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    ttdr_req_if req_ch ();
    ttdr_rsp_if rsp_ch ();

    table_mirror mirror = new();

    // Idling is enabled for most of the run and turned off for the last phase.
    bit idling       = 1'b1;
    // The stimulus raises this flag. The answer throttle then holds ready low for a long
    // stretch and clears the flag again.
    bit hold_answers = 1'b0;

    // Keys of recent stores. Probes and colliding stores draw on them so that probes can
    // hit and stores often land in occupied slots.
    logic [KEY_W-1:0] recent_keys[$];

    // Settings for each random phase. The sizes include zero, the built size, and values
    // above it up to the register maximum. An exact code of -1 means a random one.
    int phase_size [PHASES] = '{0, 1, 3, 16, 4095, 8191, 64, 2, 4096, 4097};
    int phase_exact[PHASES] = '{255, 0, 7, -1, 255, 0, -1, 128, -1, 1};

    transposition_table_depth_replace u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Both channels are sampled at the rising edge. A request transfer is predicted when
    // it is accepted, and a result transfer is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                mirror.note_request(t_request'{req_ch.req_type, req_ch.position_key,
                                               req_ch.score_in, req_ch.depth_in,
                                               req_ch.node_kind_in, req_ch.move_in});
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                mirror.check_answer(t_answer'{rsp_ch.hit, rsp_ch.score_out,
                                              rsp_ch.depth_out, rsp_ch.node_kind_out,
                                              rsp_ch.move_out, rsp_ch.occupied_count});
            end
        end
    end

    // The result side is throttled here. Ready drops in random bursts, and once in the
    // run it stays low for a long stretch. During that stretch one result sits in the
    // output register and a second one is finished behind it, so the block stops taking
    // requests.
    initial begin : answer_throttle
        int unsigned held;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_answers) begin
                rsp_ch.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
                hold_answers = 1'b0;
            end else if (idling && $urandom_range(0, 9) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_request make_request(logic [REQ_W-1:0] op, logic [KEY_W-1:0] key,
                                              logic signed [SCORE_W-1:0] score,
                                              logic [DEPTH_W-1:0] depth,
                                              logic [KIND_W-1:0] kind,
                                              logic [MOVE_W-1:0] move);
        return t_request'{op, key, score, depth, kind, move};
    endfunction

    // Presents one request at the falling edge and holds it until the transfer happens.
    task automatic send_request(input t_request r);
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.op;
        req_ch.position_key <= r.key;
        req_ch.score_in     <= r.score;
        req_ch.depth_in     <= r.depth;
        req_ch.node_kind_in <= r.kind;
        req_ch.move_in      <= r.move;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // A gap on the request side. With at_idle set, the gap starts only when the block
    // shows ready. It then falls just where the block could have taken the next request,
    // and not inside the long divide.
    task automatic pause_requests(input int unsigned cycles, input bit at_idle);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        if (at_idle) begin
            do @(posedge clk); while (!req_ch.ready);
        end
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Waits until every result has been taken and then lets the given settle cycles pass.
    // After that the block is idle and a register may be written.
    task automatic wait_for_idle(input int unsigned settle);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (mirror.due_answers.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        mirror.set_config(idx, data);
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        t_request    item;
        int unsigned roll;
        int unsigned pick;
        int unsigned ages_left;
        int          exact_pick;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_STORE;
        req_ch.position_key = '0;
        req_ch.score_in     = '0;
        req_ch.depth_in     = '0;
        req_ch.node_kind_in = '0;
        req_ch.move_in      = '0;
        ages_left           = AGE_BUDGET - 2;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // The directed part runs with the reset settings: a size of 4096 and exact code 0.
        // The first request also waits out the clearing pass that follows reset.
        send_request(make_request(REQ_PROBE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));
        send_request(make_request(REQ_STORE, 64'd0, 16'sh7FFF, 8'd0, 8'd0, 16'd0));
        send_request(make_request(REQ_PROBE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));
        // Same slot with another key: the stored key does not match, so this misses.
        send_request(make_request(REQ_PROBE, 64'd4096, 16'sd0, 8'd0, 8'd0, 16'd0));
        // Equal depth, and the new node is not exact, so the resident entry stays.
        send_request(make_request(REQ_STORE, 64'd4096, 16'sd1, 8'd0, 8'd1, 16'd1));
        send_request(make_request(REQ_PROBE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));
        // All ones in every field but the score. The key maps to the last slot.
        send_request(make_request(REQ_STORE, '1, 16'sh8000, 8'd255, 8'd255, 16'hFFFF));
        send_request(make_request(REQ_PROBE, '1, 16'sd0, 8'd0, 8'd0, 16'd0));
        // Smaller depth into the last slot: the resident entry stays.
        send_request(make_request(REQ_STORE, 64'hFFFF_FFFF_FFFF_EFFF, 16'sd5, 8'd254,
                                  8'd0, 16'd2));
        send_request(make_request(REQ_PROBE, 64'hFFFF_FFFF_FFFF_EFFF, 16'sd0, 8'd0, 8'd0,
                                  16'd0));
        // Equal depth: an exact node replaces a bound, but not another exact node.
        send_request(make_request(REQ_STORE, 64'd5, 16'sd100, 8'd3, 8'd9, 16'd3));
        send_request(make_request(REQ_STORE, 64'd4101, 16'sd200, 8'd3, 8'd0, 16'd4));
        send_request(make_request(REQ_PROBE, 64'd4101, 16'sd0, 8'd0, 8'd0, 16'd0));
        send_request(make_request(REQ_STORE, 64'd8197, 16'sd300, 8'd3, 8'd0, 16'd5));
        // A deeper result always replaces, whatever its node kind.
        send_request(make_request(REQ_STORE, 64'd5, 16'sd400, 8'd4, 8'd9, 16'd6));
        send_request(make_request(REQ_PROBE, 64'd5, 16'sd0, 8'd0, 8'd0, 16'd0));
        // The unused code changes nothing and returns a bare miss.
        send_request(make_request(REQ_UNUSED, '1, 16'sh7FFF, 8'd255, 8'd255, 16'hFFFF));
        send_request(make_request(REQ_AGE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));
        // Once aged, a slot takes any store, even a shallower one that is not exact.
        send_request(make_request(REQ_STORE, 64'h8000_0000_0000_0FFF, -16'sd1, 8'd0,
                                  8'd7, 16'd7));
        send_request(make_request(REQ_PROBE, 64'h8000_0000_0000_0FFF, 16'sd0, 8'd0, 8'd0,
                                  16'd0));
        send_request(make_request(REQ_PROBE, '1, 16'sd0, 8'd0, 8'd0, 16'd0));
        send_request(make_request(REQ_STORE, 64'd0, -16'sd300, 8'd0, 8'd1, 16'd8));
        send_request(make_request(REQ_PROBE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));
        send_request(make_request(REQ_AGE, 64'd0, 16'sd0, 8'd0, 8'd0, 16'd0));

        // In the random phases the table is not cleared between settings. Entries
        // written under one size stay where they are when the next size applies.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_idle(SETTLE_CYCLES);
            write_register(CFG_SLOTS_IN_USE, CFG_W'(phase_size[p]));
            exact_pick = (phase_exact[p] < 0) ? int'($urandom_range(0, 255)) : phase_exact[p];
            write_register(CFG_EXACT_CODE, CFG_W'(exact_pick));
            if (p == PHASES - 1) idling = 1'b0;
            if (p == PRESSURE_PHASE) hold_answers = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2 && ages_left > 0) begin
                    item.op = REQ_AGE;
                    ages_left--;
                end else if (roll < 48) begin
                    item.op = REQ_STORE;
                end else if (roll < 95) begin
                    item.op = REQ_PROBE;
                end else begin
                    item.op = REQ_UNUSED;
                end

                // Keys: reuse a recent key, add a multiple of the size to one so that it
                // lands in the same slot, take one near the top of the range, or pick a
                // fresh random one.
                pick = $urandom_range(0, 9);
                if (recent_keys.size() > 0 && pick < 5) begin
                    item.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                end else if (recent_keys.size() > 0 && pick < 7) begin
                    item.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)] +
                               KEY_W'(mirror.slot_count() * $urandom_range(1, 3));
                end else if (pick == 7) begin
                    item.key = '1 - KEY_W'($urandom_range(0, 9999));
                end else begin
                    item.key = {$urandom, $urandom};
                end

                item.score = SCORE_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    item.score = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                // Shallow depths mostly, so that equal depths and the exact-node rule
                // come up often.
                item.depth = ($urandom_range(0, 9) < 7) ? DEPTH_W'($urandom_range(0, 4))
                                                        : DEPTH_W'($urandom_range(0, 255));
                item.kind  = $urandom_range(0, 1) ? mirror.exact_reg : KIND_W'($urandom);
                item.move  = MOVE_W'($urandom);

                if (item.op == REQ_STORE) begin
                    recent_keys.push_back(item.key);
                    if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
                end

                if (idling && $urandom_range(0, 3) == 0)
                    pause_requests($urandom_range(1, 12), $urandom_range(0, 1));
                send_request(item);
            end
        end

        wait_for_idle(DRAIN_CYCLES);

        $display("Covered %0d requests: %0d stores, %0d probes with %0d hits, %0d age walks,",
                 mirror.stores + mirror.probes + mirror.ages + mirror.unused_ops,
                 mirror.stores, mirror.probes, mirror.hits, mirror.ages);
        $display("%0d unused codes, %0d table settings; %0d results checked, %0d mismatches.",
                 mirror.unused_ops, PHASES + 1, mirror.answers, mirror.errors);
        if (mirror.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Timed out with %0d results outstanding.", mirror.due_answers.size());
        $display("FAIL");
        $finish;
    end

endmodule
